### src/cfb_pkg.sv
package cfb_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;
    typedef logic [2:0]  slot_cnt_t;

    localparam byte_t FRAME_START = 8'h5B;
    localparam byte_t FRAME_STOP  = 8'h5D;
    localparam crc_t  CRC_INIT    = 16'hFFFF;
    localparam crc_t  CRC_POLY    = 16'hA001;

    // Up to five bytes per item: start, command, CRC high, CRC low, stop
    localparam int        NUM_SLOTS = 5;
    localparam slot_cnt_t SLOTS_MAX = 3'd5;

    // One byte of CRC-16/MODBUS, reflected, bit at a time
    function automatic crc_t crc_byte(input crc_t crc, input byte_t b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC after the start byte, worked out at elaboration
    localparam crc_t CRC_START = crc_byte(CRC_INIT, FRAME_START);

endpackage

### src/command_frame_builder_crc16_core.sv
// Frame builder: 0x5B, command, payload, CRC-16/MODBUS (high byte first), 0x5D.
// Path: an accepted item passes through the input register, then the output slot
// register; bytes leave one per cycle while m_ready is high.
// Throughput: one payload item per cycle while m_ready is high; an item emits up to
// five bytes, a closing item four or five, and a dropped item none.
// Reset (aresetn low, synchronous): both registers empty, no frame open, CRC 0xFFFF.
module command_frame_builder_crc16_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  cfb_pkg::byte_t s_in_byte,
    input  logic           s_first,
    input  logic           s_last,
    input  logic           s_valid,
    output logic           s_ready,
    output cfb_pkg::byte_t m_out_byte,
    output logic           m_frame_end,
    output logic           m_valid,
    input  logic           m_ready
);
    import cfb_pkg::*;

    // Input register
    logic  in_valid_reg, in_valid_next;
    byte_t in_byte_reg;
    logic  in_first_reg, in_last_reg;

    // Frame state
    crc_t crc_reg, crc_next;
    logic open_reg, open_next;

    // Output slots, shifted toward slot 0 as bytes leave
    byte_t     slot_reg  [NUM_SLOTS];
    byte_t     slot_next [NUM_SLOTS];
    logic      end_reg   [NUM_SLOTS];
    logic      end_next  [NUM_SLOTS];
    slot_cnt_t rem_reg, rem_next;

    logic out_free, load, take, in_live;
    crc_t crc_new;

    assign take     = m_valid && m_ready;
    assign out_free = (rem_reg == 3'd0) || (m_ready && (rem_reg == 3'd1));
    assign load     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_live  = in_first_reg || open_reg;

    assign m_valid     = (rem_reg != 3'd0);
    assign m_out_byte  = slot_reg[0];
    assign m_frame_end = end_reg[0];

    assign crc_new = crc_byte(in_first_reg ? CRC_START : crc_reg, in_byte_reg);

    // Input register control
    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    // Frame state update on load
    always_comb begin
        crc_next  = crc_reg;
        open_next = open_reg;
        if (load && in_live) begin
            if (in_last_reg) begin
                crc_next  = CRC_INIT;
                open_next = 1'b0;
            end else begin
                crc_next  = crc_new;
                open_next = 1'b1;
            end
        end
    end

    // Output slot fill or shift
    always_comb begin
        rem_next = rem_reg;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_next[i] = slot_reg[i];
            end_next[i]  = end_reg[i];
        end
        if (load) begin
            slot_next[0] = in_first_reg ? FRAME_START : in_byte_reg;
            slot_next[1] = in_first_reg ? in_byte_reg : crc_new[15:8];
            slot_next[2] = in_first_reg ? crc_new[15:8] : crc_new[7:0];
            slot_next[3] = in_first_reg ? crc_new[7:0] : FRAME_STOP;
            slot_next[4] = FRAME_STOP;
            end_next[0]  = 1'b0;
            end_next[1]  = 1'b0;
            end_next[2]  = 1'b0;
            end_next[3]  = !in_first_reg && in_last_reg;
            end_next[4]  = in_first_reg && in_last_reg;
            if (!in_live) begin
                rem_next = 3'd0;
            end else begin
                rem_next = 3'd1 + {2'b00, in_first_reg} + (in_last_reg ? 3'd3 : 3'd0);
            end
        end else if (take) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
                end_next[i]  = end_reg[i+1];
            end
            end_next[NUM_SLOTS-1] = 1'b0;
            rem_next = rem_reg - 3'd1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
            open_reg     <= 1'b0;
            rem_reg      <= 3'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            crc_reg      <= crc_next;
            open_reg     <= open_next;
            rem_reg      <= rem_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_in_byte;
            in_first_reg <= s_first;
            in_last_reg  <= s_last;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_reg[i] <= slot_next[i];
            end_reg[i]  <= end_next[i];
        end
    end

    // Checks
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= SLOTS_MAX)
        else $error("slot count above five");

    a_end_is_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> (m_out_byte == FRAME_STOP) && (rem_reg == 3'd1))
        else $error("frame end not on the final stop byte");

    a_close_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        load && in_live && in_last_reg |=> (crc_reg == CRC_INIT) && !open_reg)
        else $error("frame state not cleared after close");

    a_drop_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !in_live |=> (rem_reg == 3'd0) && $stable(crc_reg) && !open_reg)
        else $error("dropped item changed state");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cfb_pkg::*;

    localparam crc_t MODBUS_POLY    = 16'hA001;
    localparam int   RANDOM_ITEMS   = 330;
    localparam int   IDLE_PCT       = 38;
    localparam int   STALL_LIMIT    = 2000;
    localparam int   HOLD_CYCLES    = 60;
    localparam int   HOLD_AT_BYTE   = 150;
    localparam int   DRAIN_CYCLES   = 20;
    localparam int   REPORT_MAX     = 10;

    typedef struct packed {
        byte_t data;
        logic  first;
        logic  last;
    } cmd_item_t;

    typedef struct packed {
        byte_t data;
        logic  stop;
    } wire_byte_t;

    logic  aclk;
    logic  aresetn;
    byte_t s_in_byte;
    logic  s_first;
    logic  s_last;
    logic  s_valid;
    logic  s_ready;
    byte_t m_out_byte;
    logic  m_frame_end;
    logic  m_valid;
    logic  m_ready;

    command_frame_builder_crc16_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_in_byte   (s_in_byte),
        .s_first     (s_first),
        .s_last      (s_last),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    cmd_item_t  tx_items_q[$];
    wire_byte_t wire_bytes_q[$];

    // predictor state
    crc_t frame_crc;
    logic frame_open;

    logic s_fire;
    logic m_fire;
    int   items_sent;
    int   bytes_seen;
    int   mismatch_cnt;
    int   stall_cycles;
    int   hold_left;
    logic hold_done;
    cmd_item_t  next_item;
    wire_byte_t exp_byte;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // CRC-16/MODBUS, one byte, fed LSB first
    function automatic crc_t modbus_crc_step(crc_t acc, byte_t data);
        crc_t r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ data[k]) begin
                r = {1'b0, r[15:1]} ^ MODBUS_POLY;
            end else begin
                r = {1'b0, r[15:1]};
            end
        end
        return r;
    endfunction

    // append one expected wire byte
    task automatic expect_wire(byte_t data, logic stop);
        wire_byte_t w;
        w.data = data;
        w.stop = stop;
        wire_bytes_q.insert(wire_bytes_q.size(), w);
    endtask

    // wire bytes caused by one accepted command item
    task automatic frame_predict(cmd_item_t it);
        if (it.first) begin
            frame_crc  = modbus_crc_step(CRC_INIT, FRAME_START);
            frame_open = 1'b1;
            expect_wire(FRAME_START, 1'b0);
        end
        if (frame_open) begin
            frame_crc = modbus_crc_step(frame_crc, it.data);
            expect_wire(it.data, 1'b0);
            if (it.last) begin
                expect_wire(frame_crc[15:8], 1'b0);
                expect_wire(frame_crc[7:0], 1'b0);
                expect_wire(FRAME_STOP, 1'b1);
                frame_crc  = CRC_INIT;
                frame_open = 1'b0;
            end
        end
    endtask

    task automatic push_cmd(byte_t data, logic first, logic last);
        cmd_item_t c;
        c.data  = data;
        c.first = first;
        c.last  = last;
        tx_items_q.insert(tx_items_q.size(), c);
    endtask

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(0, 255));
    endfunction

    // driver: new item at the falling edge once the previous one is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_fire) begin
                if (tx_items_q.size() != 0 &&
                    ((items_sent >= 120 && items_sent < 200) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = tx_items_q.pop_front();
                    s_in_byte <= next_item.data;
                    s_first   <= next_item.first;
                    s_last    <= next_item.last;
                    s_valid   <= 1'b1;
                    items_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off, one calm stretch
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (bytes_seen >= 250 && bytes_seen < 400) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // monitor: predict on input accept, check on output accept, watchdog
    always @(posedge aclk) begin
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_fire) begin
            frame_predict('{data: s_in_byte, first: s_first, last: s_last});
        end
        if (m_fire) begin
            bytes_seen++;
            if (wire_bytes_q.size() == 0) begin
                if (mismatch_cnt < REPORT_MAX) begin
                    $display("unexpected byte: expected none, got out_byte=%02h frame_end=%b",
                             m_out_byte, m_frame_end);
                end
                mismatch_cnt++;
            end else begin
                exp_byte = wire_bytes_q.pop_front();
                if (exp_byte.data !== m_out_byte || exp_byte.stop !== m_frame_end) begin
                    if (mismatch_cnt < REPORT_MAX) begin
                        $display("byte %0d mismatch: expected %02h/%b, got %02h/%b",
                                 bytes_seen, exp_byte.data, exp_byte.stop,
                                 m_out_byte, m_frame_end);
                    end
                    mismatch_cnt++;
                end
            end
        end
        if (aresetn) begin
            if (s_fire || m_fire) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("command_frame_builder_crc16_core test failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int pick;
        int len;
        int framed;

        aresetn      = 1'b0;
        s_in_byte    = '0;
        s_first      = 1'b0;
        s_last       = 1'b0;
        s_valid      = 1'b0;
        m_ready      = 1'b0;
        s_fire       = 1'b0;
        m_fire       = 1'b0;
        frame_crc    = CRC_INIT;
        frame_open   = 1'b0;
        items_sent   = 0;
        bytes_seen   = 0;
        mismatch_cnt = 0;
        stall_cycles = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        framed       = 0;

        // directed: bytes with no frame open are dropped
        push_cmd(8'h00, 1'b0, 1'b0);
        push_cmd(8'hFF, 1'b0, 1'b1);
        // command with no payload
        push_cmd(8'h00, 1'b1, 1'b1);
        push_cmd(8'hFF, 1'b1, 1'b1);
        // full frame with payload extremes and marker look-alikes
        push_cmd(8'hA5, 1'b1, 1'b0);
        push_cmd(8'h00, 1'b0, 1'b0);
        push_cmd(8'hFF, 1'b0, 1'b0);
        push_cmd(FRAME_START, 1'b0, 1'b0);
        push_cmd(FRAME_STOP, 1'b0, 1'b0);
        push_cmd(8'h7E, 1'b0, 1'b1);
        // new command inside an open frame abandons it
        push_cmd(8'h11, 1'b1, 1'b0);
        push_cmd(8'h22, 1'b0, 1'b0);
        push_cmd(8'h33, 1'b1, 1'b0);
        push_cmd(8'h44, 1'b0, 1'b1);
        push_cmd(8'h55, 1'b1, 1'b0);
        push_cmd(8'h66, 1'b1, 1'b1);
        // stray byte right after a close
        push_cmd(8'h77, 1'b0, 1'b0);

        // random: mostly well-formed frames, some strays and abandoned frames
        while (framed < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    push_cmd(rand_byte(), 1'b0, 1'($urandom_range(0, 1)));
                end
                framed += len;
            end else if (pick < 20) begin
                len = $urandom_range(0, 3);
                push_cmd(rand_byte(), 1'b1, 1'b0);
                for (int i = 0; i < len; i++) begin
                    push_cmd(rand_byte(), 1'b0, 1'b0);
                end
                framed += len + 1;
            end else begin
                len = (pick < 25) ? $urandom_range(8, 20) : $urandom_range(0, 5);
                if (len == 0) begin
                    push_cmd(rand_byte(), 1'b1, 1'b1);
                end else begin
                    push_cmd(rand_byte(), 1'b1, 1'b0);
                    for (int i = 1; i < len; i++) begin
                        push_cmd(rand_byte(), 1'b0, 1'b0);
                    end
                    push_cmd(rand_byte(), 1'b0, 1'b1);
                end
                framed += len + 1;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all items taken, then all expected bytes out, then a short drain
        @(negedge aclk);
        while (tx_items_q.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (wire_bytes_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_cnt == 0 && wire_bytes_q.size() == 0) begin
            $display("command_frame_builder_crc16_core test passed");
        end else begin
            $display("command_frame_builder_crc16_core test failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/cfb_pkg.sv
src/command_frame_builder_crc16_core.sv
tb/testbench.sv
